@@ rtl/core/gsr_pkg.sv @@
package gsr_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned WeightW = 5;
  localparam int unsigned MixW = 13;
  localparam int unsigned CfgIdxW = 2;

  // Weight saturates here: a spill of this size or more moves fully to the target.
  localparam logic [WeightW-1:0] FullSpill = 5'd24;
  // Half of the weight denominator, for round half up.
  localparam logic [MixW-1:0] HalfSpill = 13'd12;
  // floor(u / 3) == (u * DivThreeRecip) >> DivThreeShift for every u below 2048.
  localparam logic [10:0] DivThreeRecip = 11'd683;
  localparam int unsigned DivThreeShift = 11;

  localparam logic [CfgIdxW-1:0] CfgTargetRed = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetGreen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTargetBlue = 2'd2;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
    logic             was_changed;
  } pix_out_t;

  // Intermediate stage: weighted sums before the divide by 24.
  typedef struct packed {
    logic [MixW-1:0]  mix_red;
    logic [MixW-1:0]  mix_green;
    logic [MixW-1:0]  mix_blue;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             changed;
  } mid_t;

endpackage

@@ rtl/core/gsr_mix.sv @@
module gsr_mix
  import gsr_pkg::*;
(
  input  logic [ChanW-1:0]   x_i,
  input  logic [ChanW-1:0]   s_i,
  input  logic [WeightW-1:0] w_i,
  output logic [MixW-1:0]    mix_o
);

  logic [WeightW-1:0] keep;
  logic [MixW-1:0]    prod_x;
  logic [MixW-1:0]    prod_s;
  logic [MixW:0]      sum;

  // (24 - w) * x + w * s + 12, which is 24 times the blended value plus a half.
  assign keep   = FullSpill - w_i;
  assign prod_x = MixW'(keep) * MixW'(x_i);
  assign prod_s = MixW'(w_i) * MixW'(s_i);
  assign sum    = (MixW+1)'(prod_x) + (MixW+1)'(prod_s) + (MixW+1)'(HalfSpill);
  assign mix_o  = sum[MixW-1:0];

endmodule

@@ rtl/core/gsr_div24.sv @@
module gsr_div24
  import gsr_pkg::*;
(
  input  logic [MixW-1:0]  mix_i,
  output logic [ChanW-1:0] quo_o
);

  logic [MixW-4:0] eighth;
  logic [20:0]     prod;

  // Divide by 8 with a shift, then by 3 with a reciprocal multiply.
  assign eighth = mix_i[MixW-1:3];
  assign prod   = 21'(eighth) * 21'(DivThreeRecip);
  assign quo_o  = prod[DivThreeShift+ChanW-1:DivThreeShift];

endmodule

@@ rtl/core/green_spill_recolour_pixel.sv @@
// Channel  | Direction | Handshake              | Payload
// pixel in | input     | in_valid_i / in_stall_o | in_data_i (pix_in_t)
// pixel out| output    | out_valid_o / out_stall_i | out_data_o (pix_out_t)
// config   | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One pixel is accepted every cycle while in_stall_o is low; its result is presented from the
// result register and transfers out when out_stall_i is low.
// The three stages are the input register, the weighted-sum register and the result register.
// Each stage advances when it is empty or the stage after it advances, so a stall on the
// output only backs up into the input once all three stages hold a pixel.
// Reset clears the stage valid bits and sets all target registers to zero.
module green_spill_recolour_pixel
  import gsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ChanW-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pix_out_t             out_data_o
);

  logic [ChanW-1:0] tgt_red_q, tgt_green_q, tgt_blue_q;

  logic    in_valid_q, mid_valid_q, out_valid_q;
  pix_in_t in_q;
  mid_t    mid_q, mid_d;
  pix_out_t out_q, out_d;

  logic adv_out, adv_mid, adv_in;

  logic [ChanW-1:0]   floor_val;
  logic [ChanW-1:0]   spill;
  logic [WeightW-1:0] weight;
  logic [ChanW-1:0]   quo_red, quo_green, quo_blue;
  logic [MixW-1:0]    mix_red, mix_green, mix_blue;

  assign adv_out = !out_valid_q || !out_stall_i;
  assign adv_mid = !mid_valid_q || adv_out;
  assign adv_in  = !in_valid_q || adv_mid;

  assign in_stall_o  = !adv_in;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_red_q   <= '0;
      tgt_green_q <= '0;
      tgt_blue_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTargetRed:   tgt_red_q   <= cfg_data_i;
        CfgTargetGreen: tgt_green_q <= cfg_data_i;
        CfgTargetBlue:  tgt_blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Spill detection and weight.
  always_comb begin
    floor_val = (in_q.in_red > in_q.in_blue) ? in_q.in_red : in_q.in_blue;
    spill     = in_q.in_green - floor_val;
    weight    = (spill >= ChanW'(FullSpill)) ? FullSpill : spill[WeightW-1:0];
  end

  gsr_mix u_mix_red (
    .x_i  (in_q.in_red),
    .s_i  (tgt_red_q),
    .w_i  (weight),
    .mix_o(mix_red)
  );

  gsr_mix u_mix_green (
    .x_i  (floor_val),
    .s_i  (tgt_green_q),
    .w_i  (weight),
    .mix_o(mix_green)
  );

  gsr_mix u_mix_blue (
    .x_i  (in_q.in_blue),
    .s_i  (tgt_blue_q),
    .w_i  (weight),
    .mix_o(mix_blue)
  );

  always_comb begin
    mid_d.mix_red   = mix_red;
    mid_d.mix_green = mix_green;
    mid_d.mix_blue  = mix_blue;
    mid_d.red       = in_q.in_red;
    mid_d.green     = in_q.in_green;
    mid_d.blue      = in_q.in_blue;
    mid_d.alpha     = in_q.in_alpha;
    mid_d.changed   = (in_q.in_alpha != '0) && (in_q.in_green > floor_val);
  end

  gsr_div24 u_div_red (
    .mix_i(mid_q.mix_red),
    .quo_o(quo_red)
  );

  gsr_div24 u_div_green (
    .mix_i(mid_q.mix_green),
    .quo_o(quo_green)
  );

  gsr_div24 u_div_blue (
    .mix_i(mid_q.mix_blue),
    .quo_o(quo_blue)
  );

  always_comb begin
    out_d.out_alpha   = mid_q.alpha;
    out_d.was_changed = mid_q.changed;
    if (mid_q.changed) begin
      out_d.out_red   = quo_red;
      out_d.out_green = quo_green;
      out_d.out_blue  = quo_blue;
    end else begin
      out_d.out_red   = mid_q.red;
      out_d.out_green = mid_q.green;
      out_d.out_blue  = mid_q.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_valid_q <= in_valid_i;
      end
      if (adv_mid) begin
        mid_valid_q <= in_valid_q;
      end
      if (adv_out) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv_mid && in_valid_q) begin
      mid_q <= mid_d;
    end
    if (adv_out && mid_valid_q) begin
      out_q <= out_d;
    end
  end

endmodule
